// ===== hdl/wtf_pkg.sv =====
// Package for the word frequency table: request codes, widths and the
// delimiter and digit tests. No dependencies.
package wtf_pkg;

  localparam int unsigned ReqW = 2;
  localparam logic [ReqW-1:0] REQ_BYTE = 2'd0;
  localparam logic [ReqW-1:0] REQ_EOF  = 2'd1;
  localparam logic [ReqW-1:0] REQ_READ = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_QUEST = 8'h3F;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  localparam logic [15:0] CountMax    = 16'hFFFF;
  localparam logic [23:0] FileWordMax = 24'hFFFFFF;
  localparam logic [31:0] TotalMax    = 32'hFFFFFFFF;
  localparam logic [8:0]  FileNewMax  = 9'h1FF;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_NL) || (c == CHAR_DOT) ||
           (c == CHAR_COMMA) || (c == CHAR_COLON) || (c == CHAR_SEMI) ||
           (c == CHAR_BANG) || (c == CHAR_QUEST);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== hdl/word_tokenizer_frequency_table.sv =====
// Word frequency table top level: tokenizer, table memories and search sequencer.
// Depends on wtf_pkg.
//
// A text byte that does not end a word passes through S_RESP. A delimiter that
// ends a word starts a search over the used entries, which reads one entry at a
// time from the length/count memory and the packed word memory in S_SRCH and
// S_CMP, then writes back. A read beat passes through S_RDREQ and S_RDOUT. After
// reset a clearing pass over every entry runs with busy high. Each beat gets one
// result, shown for one cycle with done_o; the receiver cannot stall.
module word_tokenizer_frequency_table
  import wtf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned WORD_LEN    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  read_index_i,
  input  logic [3:0]  read_pos_i,
  output logic        done_o,
  output logic        word_done_o,
  output logic        new_word_o,
  output logic        table_full_o,
  output logic [7:0]  entry_index_o,
  output logic [15:0] entry_count_o,
  output logic [8:0]  unique_words_o,
  output logic [23:0] file_words_o,
  output logic [8:0]  file_new_words_o,
  output logic [31:0] global_words_o,
  output logic [7:0]  read_char_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PosW = $clog2(WORD_LEN);
  localparam int unsigned LenW = $clog2(WORD_LEN + 1);
  localparam int unsigned WordW = 8 * WORD_LEN;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RDREQ = 7'b0000100,
    S_RDOUT = 7'b0001000,
    S_SRCH  = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Length+count memory and word memory share one address.
  logic [LenW+15:0] meta_mem [TABLE_DEPTH];
  logic [WordW-1:0] word_mem [TABLE_DEPTH];
  logic [LenW+15:0] meta_rd_q;
  logic [WordW-1:0] word_rd_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_addr, wr_addr;
  logic [LenW+15:0] meta_wd;
  logic [WordW-1:0] word_wd;
  logic             word_we;

  logic [WordW-1:0] pend_q, pend_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [23:0]      fw_q, fw_d;
  logic [8:0]       fn_q, fn_d;
  logic [31:0]      tw_q, tw_d;
  logic [UsedW-1:0] ptr_q, ptr_d;
  logic [1:0]       req_q, req_d;
  logic [7:0]       rix_q, rix_d;
  logic [3:0]       rpos_q, rpos_d;

  logic             done_d, wd_d, nw_d, tf_d;
  logic [7:0]       ei_d, rc_d;
  logic [15:0]      ec_d;
  logic [23:0]      fwo_d;
  logic [8:0]       fno_d;

  logic             accept;
  logic [LenW-1:0]  m_len;
  logic [15:0]      m_cnt;
  logic             match;
  logic [WordW-1:0] mask;
  logic             rd_valid;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign m_len  = meta_rd_q[LenW+15:16];
  assign m_cnt  = meta_rd_q[15:0];

  always_comb begin
    mask = '0;
    for (int i = 0; i < WORD_LEN; i++) begin
      if (i < int'(plen_q)) mask[8*i +: 8] = 8'hFF;
    end
  end

  assign match = (m_len == plen_q) && (((word_rd_q ^ pend_q) & mask) == '0);
  assign rd_valid = (32'(rix_q) < 32'(used_q)) && (32'(rix_q) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) meta_mem[wr_addr] <= meta_wd;
    if (word_we) word_mem[wr_addr] <= word_wd;
    meta_rd_q <= meta_mem[mem_addr];
    word_rd_q <= word_mem[mem_addr];
  end

  always_comb begin
    state_d = state_q;
    pend_d = pend_q; plen_d = plen_q; used_d = used_q;
    fw_d = fw_q; fn_d = fn_q; tw_d = tw_q; ptr_d = ptr_q;
    req_d = req_q; rix_d = rix_q; rpos_d = rpos_q;
    done_d = 1'b0; wd_d = 1'b0; nw_d = 1'b0; tf_d = 1'b0;
    ei_d = '0; ec_d = '0; rc_d = '0;
    fwo_d = fw_q; fno_d = fn_q;
    mem_we = 1'b0; word_we = 1'b0; wr_addr = ptr_q[IdxW-1:0];
    meta_wd = '0; word_wd = '0;
    mem_addr = ptr_q[IdxW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (32'(ptr_q) == TABLE_DEPTH - 1) begin
          state_d = S_IDLE;
          ptr_d = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_d = req_type_i; rix_d = read_index_i; rpos_d = read_pos_i;
          state_d = S_RESP;
          if (req_type_i == REQ_BYTE) begin
            if (is_delim(data_byte_i)) begin
              if (plen_q >= LenW'(2)) begin
                ptr_d = '0;
                state_d = S_SRCH;
              end else begin
                plen_d = '0;
              end
            end else if (!is_digit(data_byte_i) && (32'(plen_q) < WORD_LEN)) begin
              pend_d[8*PosW'(plen_q) +: 8] = data_byte_i;
              plen_d = plen_q + 1'b1;
            end
          end else if (req_type_i == REQ_READ) begin
            state_d = S_RDREQ;
          end
        end
      end
      S_RDREQ: begin
        mem_addr = IdxW'(rix_q);
        state_d = S_RDOUT;
      end
      S_RDOUT: begin
        state_d = S_IDLE;
        done_d = 1'b1;
        ei_d = rix_q;
        if (rd_valid) begin
          ec_d = m_cnt;
          if ((32'(rpos_q) < 32'(m_len)) && (32'(rpos_q) < WORD_LEN))
            rc_d = word_rd_q[8*PosW'(rpos_q) +: 8];
        end
      end
      S_SRCH: begin
        if (ptr_q >= used_q) begin
          // Miss: insert or flag full.
          state_d = S_IDLE;
          done_d = 1'b1; wd_d = 1'b1;
          fw_d = (fw_q < FileWordMax) ? fw_q + 1'b1 : fw_q;
          tw_d = (tw_q < TotalMax) ? tw_q + 1'b1 : tw_q;
          plen_d = '0;
          if (32'(used_q) < TABLE_DEPTH) begin
            mem_we = 1'b1; word_we = 1'b1;
            wr_addr = used_q[IdxW-1:0];
            meta_wd = {plen_q, 16'd1};
            word_wd = pend_q & mask;
            used_d = used_q + 1'b1;
            fn_d = (fn_q < FileNewMax) ? fn_q + 1'b1 : fn_q;
            nw_d = 1'b1;
            ei_d = 8'(used_q);
            ec_d = 16'd1;
          end else begin
            tf_d = 1'b1;
          end
          fwo_d = fw_d; fno_d = fn_d;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (match) begin
          state_d = S_IDLE;
          done_d = 1'b1; wd_d = 1'b1;
          fw_d = (fw_q < FileWordMax) ? fw_q + 1'b1 : fw_q;
          tw_d = (tw_q < TotalMax) ? tw_q + 1'b1 : tw_q;
          plen_d = '0;
          mem_we = 1'b1;
          ec_d = (m_cnt < CountMax) ? m_cnt + 1'b1 : m_cnt;
          meta_wd = {m_len, ec_d};
          ei_d = 8'(ptr_q);
          fwo_d = fw_d;
        end else begin
          ptr_d = ptr_q + 1'b1;
          state_d = S_SRCH;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
        done_d = 1'b1;
        if (req_q == REQ_EOF) begin
          plen_d = '0; fw_d = '0; fn_d = '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      plen_q <= '0; used_q <= '0; fw_q <= '0; fn_q <= '0; tw_q <= '0;
      ptr_q <= '0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      plen_q <= plen_d; used_q <= used_d; fw_q <= fw_d; fn_q <= fn_d;
      tw_q <= tw_d; ptr_q <= ptr_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    req_q <= req_d; rix_q <= rix_d; rpos_q <= rpos_d;
    word_done_o <= wd_d; new_word_o <= nw_d; table_full_o <= tf_d;
    entry_index_o <= ei_d; entry_count_o <= ec_d; read_char_o <= rc_d;
    file_words_o <= fwo_d; file_new_words_o <= fno_d;
  end

  assign unique_words_o = 9'(used_q);
  assign global_words_o = tw_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !done_o) else $error("result in the cycle after accept");
  a_new_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(new_word_o && table_full_o)) else $error("new and full together");
  a_used_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
    else $error("entry count jumped");

endmodule
